// ----- src/gcc_pkg.sv -----
// Shared types, constants and the reciprocal table for the greedy coin change block.
package gcc_pkg;

	// Field widths.
	localparam int AMT_W     = 16;
	localparam int COIN_W    = 6;
	localparam int CNT_W     = 16;
	localparam int STATUS_W  = 2;

	// Coin slot register file.
	localparam int SLOT_CNT   = 8;
	localparam int SLOT_IDX_W = 3;
	localparam int RANK_W     = 3;

	localparam int NUM_COINS_DEF = 8;

	localparam logic [COIN_W-1:0] COIN_MAX  = 6'd50;
	localparam logic [COIN_W-1:0] COIN_ONE  = 6'd1;
	localparam logic [COIN_W-1:0] COIN_NONE = 6'd0;

	// Quotient by reciprocal: q = (n * ceil(2^22 / d)) >> 22 is exact for 16-bit n, d < 64.
	localparam int RCP_W     = 23;
	localparam int RCP_SHIFT = 22;
	localparam int PROD_W    = AMT_W + RCP_W;
	localparam int QD_W      = CNT_W + COIN_W;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_BAD_SET  = 2'd1,
		ST_ZERO_AMT = 2'd2
	} status_t;

	// What travels alongside the counts from one denomination stage to the next.
	typedef struct packed {
		logic                 vld;
		status_t              status;
		logic [AMT_W-1:0]     rest;
	} lane_t;

	// Reciprocal table, rounded up; unused and out-of-range values give zero.
	function automatic logic [RCP_W-1:0] recip(input logic [COIN_W-1:0] d);
		logic [RCP_W-1:0] r;
		case (d)
			6'd1:    r = 23'd4194304;
			6'd2:    r = 23'd2097152;
			6'd3:    r = 23'd1398102;
			6'd4:    r = 23'd1048576;
			6'd5:    r = 23'd838861;
			6'd6:    r = 23'd699051;
			6'd7:    r = 23'd599187;
			6'd8:    r = 23'd524288;
			6'd9:    r = 23'd466034;
			6'd10:   r = 23'd419431;
			6'd11:   r = 23'd381301;
			6'd12:   r = 23'd349526;
			6'd13:   r = 23'd322639;
			6'd14:   r = 23'd299594;
			6'd15:   r = 23'd279621;
			6'd16:   r = 23'd262144;
			6'd17:   r = 23'd246724;
			6'd18:   r = 23'd233017;
			6'd19:   r = 23'd220753;
			6'd20:   r = 23'd209716;
			6'd21:   r = 23'd199729;
			6'd22:   r = 23'd190651;
			6'd23:   r = 23'd182362;
			6'd24:   r = 23'd174763;
			6'd25:   r = 23'd167773;
			6'd26:   r = 23'd161320;
			6'd27:   r = 23'd155345;
			6'd28:   r = 23'd149797;
			6'd29:   r = 23'd144632;
			6'd30:   r = 23'd139811;
			6'd31:   r = 23'd135301;
			6'd32:   r = 23'd131072;
			6'd33:   r = 23'd127101;
			6'd34:   r = 23'd123362;
			6'd35:   r = 23'd119838;
			6'd36:   r = 23'd116509;
			6'd37:   r = 23'd113360;
			6'd38:   r = 23'd110377;
			6'd39:   r = 23'd107547;
			6'd40:   r = 23'd104858;
			6'd41:   r = 23'd102301;
			6'd42:   r = 23'd99865;
			6'd43:   r = 23'd97542;
			6'd44:   r = 23'd95326;
			6'd45:   r = 23'd93207;
			6'd46:   r = 23'd91181;
			6'd47:   r = 23'd89241;
			6'd48:   r = 23'd87382;
			6'd49:   r = 23'd85599;
			6'd50:   r = 23'd83887;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ----- src/gcc_cfg.sv -----
// Coin slot registers and the sorted list of distinct denominations derived from them.
module gcc_cfg #(
	parameter int NUM_COINS = gcc_pkg::NUM_COINS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     wr_en,
	input  logic [gcc_pkg::SLOT_IDX_W-1:0]           wr_index,
	input  logic [gcc_pkg::COIN_W-1:0]               wr_data,
	output logic [NUM_COINS-1:0][gcc_pkg::COIN_W-1:0] denom,
	output logic                                     bad
);
	import gcc_pkg::*;

	logic [COIN_W-1:0]                 coin_q [SLOT_CNT];
	logic [NUM_COINS-1:0][COIN_W-1:0]  denom_d;
	logic [NUM_COINS-1:0][COIN_W-1:0]  denom_q;
	logic                              bad_d;
	logic                              bad_q;
	logic [NUM_COINS-1:0]              used;
	logic [NUM_COINS-1:0]              first;
	logic [RANK_W-1:0]                 rank [NUM_COINS];
	logic                              have_one;
	logic                              over_max;

	// Slot registers; after reset only slot 0 holds a coin of value one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SLOT_CNT; s++) begin
				coin_q[s] <= (s == 0) ? COIN_ONE : COIN_NONE;
			end
		end else if (wr_en) begin
			coin_q[wr_index] <= wr_data;
		end
	end

	// Rank every first occurrence of a value by how many distinct values exceed it.
	always_comb begin
		used     = '0;
		first    = '0;
		have_one = 1'b0;
		over_max = 1'b0;
		for (int i = 0; i < NUM_COINS; i++) begin
			used[i] = (coin_q[i] != COIN_NONE);
			if (used[i] && coin_q[i] > COIN_MAX) begin
				over_max = 1'b1;
			end
			if (coin_q[i] == COIN_ONE) begin
				have_one = 1'b1;
			end
		end
		for (int i = 0; i < NUM_COINS; i++) begin
			first[i] = used[i];
			for (int j = 0; j < NUM_COINS; j++) begin
				if (j < i && used[j] && coin_q[j] == coin_q[i]) begin
					first[i] = 1'b0;
				end
			end
		end
		for (int i = 0; i < NUM_COINS; i++) begin
			rank[i] = '0;
			for (int j = 0; j < NUM_COINS; j++) begin
				if (first[j] && coin_q[j] > coin_q[i]) begin
					rank[i] = rank[i] + 1'b1;
				end
			end
		end
		for (int r = 0; r < NUM_COINS; r++) begin
			denom_d[r] = COIN_NONE;
			for (int i = 0; i < NUM_COINS; i++) begin
				if (first[i] && rank[i] == RANK_W'(r)) begin
					denom_d[r] = coin_q[i];
				end
			end
		end
		bad_d = over_max || !have_one;
	end

	// The sorted list follows the slots in the next cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NUM_COINS; r++) begin
				denom_q[r] <= (r == 0) ? COIN_ONE : COIN_NONE;
			end
			bad_q <= 1'b0;
		end else begin
			denom_q <= denom_d;
			bad_q   <= bad_d;
		end
	end

	assign denom = denom_q;
	assign bad   = bad_q;

endmodule

// ----- src/gcc_rank.sv -----
// One denomination of the greedy split: a reciprocal multiply stage and a remainder stage.
module gcc_rank #(
	parameter int NUM_COINS = gcc_pkg::NUM_COINS_DEF,
	parameter int RANK      = 0
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    adv,
	input  gcc_pkg::lane_t                          in_lane,
	input  logic [NUM_COINS-1:0][gcc_pkg::CNT_W-1:0] in_cnt,
	input  logic [gcc_pkg::COIN_W-1:0]              denom,
	output gcc_pkg::lane_t                          out_lane,
	output logic [NUM_COINS-1:0][gcc_pkg::CNT_W-1:0] out_cnt
);
	import gcc_pkg::*;

	logic [PROD_W-1:0]               prod;
	logic [QD_W-1:0]                 qd;
	logic [NUM_COINS-1:0][CNT_W-1:0] cnt_nx;

	logic                            vld_s1;
	status_t                         status_s1;
	logic [AMT_W-1:0]                rest_s1;
	logic [CNT_W-1:0]                quo_s1;
	logic [NUM_COINS-1:0][CNT_W-1:0] cnt_s1;

	logic                            vld_s2;
	status_t                         status_s2;
	logic [AMT_W-1:0]                rest_s2;
	logic [NUM_COINS-1:0][CNT_W-1:0] cnt_s2;

	// Quotient of the remaining amount by this denomination.
	assign prod = PROD_W'(in_lane.rest) * PROD_W'(recip(denom));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_lane.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_s1 <= in_lane.status;
			rest_s1   <= in_lane.rest;
			quo_s1    <= prod[RCP_SHIFT +: CNT_W];
			cnt_s1    <= in_cnt;
		end
	end

	// Take the coins out of the amount and record how many were used.
	assign qd = QD_W'(quo_s1) * QD_W'(denom);

	always_comb begin
		cnt_nx       = cnt_s1;
		cnt_nx[RANK] = quo_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_s2 <= status_s1;
			rest_s2   <= rest_s1 - qd[AMT_W-1:0];
			cnt_s2    <= cnt_nx;
		end
	end

	assign out_lane = '{vld: vld_s2, status: status_s2, rest: rest_s2};
	assign out_cnt  = cnt_s2;

endmodule

// ----- src/greedy_coin_change_top.sv -----
// Greedy coin change: a pipeline of denomination stages followed by a result serialiser.
// An accepted item is registered at entry, passes the stages of every denomination, then the
// serialiser and the result register. Results leave one per cycle; an item yields one to
// NUM_COINS results, and the serialiser takes the next item as it sends the last of the current one.
// Busy rises only while the last pipeline stage waits for the serialiser to drain.
// Reset clears all valid bits and sets the coin set to a single coin of value one.
module greedy_coin_change_top #(
	parameter int NUM_COINS = gcc_pkg::NUM_COINS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [gcc_pkg::AMT_W-1:0]       amount,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [gcc_pkg::SLOT_IDX_W-1:0]  cfg_index,
	input  logic [gcc_pkg::COIN_W-1:0]      cfg_data,
	output logic                            strobe,
	output logic [gcc_pkg::COIN_W-1:0]      coin_value,
	output logic [gcc_pkg::CNT_W-1:0]       coin_count,
	output logic [gcc_pkg::STATUS_W-1:0]    status,
	output logic                            last
);
	import gcc_pkg::*;

	logic [NUM_COINS-1:0][COIN_W-1:0] denom;
	logic                             bad;
	logic                             adv;

	logic                             vld_s1;
	logic [AMT_W-1:0]                 amt_s1;
	status_t                          entry_status;

	lane_t                            ch_lane [NUM_COINS+1];
	logic [NUM_COINS-1:0][CNT_W-1:0]  ch_cnt  [NUM_COINS+1];
	lane_t                            fin_lane;

	logic                             ser_act_q;
	status_t                          ser_status_q;
	logic [NUM_COINS-1:0]             ser_mask_q;
	logic [NUM_COINS-1:0][CNT_W-1:0]  ser_cnt_q;
	logic [NUM_COINS-1:0]             sel_oh;
	logic [NUM_COINS-1:0]             mask_rest;
	logic                             ser_last;
	logic                             ser_free;
	logic [NUM_COINS-1:0]             fin_mask;
	logic [COIN_W-1:0]                sel_value;
	logic [CNT_W-1:0]                 sel_count;

	logic                             strobe_q;
	logic [COIN_W-1:0]                coin_value_q;
	logic [CNT_W-1:0]                 coin_count_q;
	status_t                          status_q;
	logic                             last_q;

	// Configuration is always taken at once.
	assign cfg_ready = 1'b1;

	gcc_cfg #(
		.NUM_COINS (NUM_COINS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.denom    (denom),
		.bad      (bad)
	);

	// The whole pipeline moves together unless the last stage cannot hand over.
	assign fin_lane = ch_lane[NUM_COINS];
	assign adv      = !fin_lane.vld || ser_free;
	assign busy     = !adv;

	// Entry stage: register the accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			amt_s1 <= amount;
		end
	end

	// The coin set check comes before the amount check.
	always_comb begin
		if (bad) begin
			entry_status = ST_BAD_SET;
		end else if (amt_s1 == '0) begin
			entry_status = ST_ZERO_AMT;
		end else begin
			entry_status = ST_OK;
		end
	end

	assign ch_lane[0] = '{vld: vld_s1, status: entry_status, rest: amt_s1};
	assign ch_cnt[0]  = '0;

	// One pair of stages per denomination, largest first.
	for (genvar k = 0; k < NUM_COINS; k++) begin : g_rank
		gcc_rank #(
			.NUM_COINS (NUM_COINS),
			.RANK      (k)
		) u_rank (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.in_lane  (ch_lane[k]),
			.in_cnt   (ch_cnt[k]),
			.denom    (denom[k]),
			.out_lane (ch_lane[k+1]),
			.out_cnt  (ch_cnt[k+1])
		);
	end

	// Serialiser: pick the largest denomination still pending.
	always_comb begin
		sel_oh    = ser_mask_q & (~ser_mask_q + NUM_COINS'(1));
		mask_rest = ser_mask_q & ~sel_oh;
		ser_last  = (ser_status_q != ST_OK) || (mask_rest == '0);
		ser_free  = !ser_act_q || ser_last;
		sel_value = '0;
		sel_count = '0;
		for (int k = 0; k < NUM_COINS; k++) begin
			if (sel_oh[k]) begin
				sel_value = denom[k];
				sel_count = ser_cnt_q[k];
			end
			fin_mask[k] = (ch_cnt[NUM_COINS][k] != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_act_q <= 1'b0;
		end else if (fin_lane.vld && ser_free) begin
			ser_act_q <= 1'b1;
		end else if (ser_act_q && ser_last) begin
			ser_act_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_lane.vld && ser_free) begin
			ser_status_q <= fin_lane.status;
			ser_mask_q   <= fin_mask;
			ser_cnt_q    <= ch_cnt[NUM_COINS];
		end else if (ser_act_q) begin
			ser_mask_q   <= mask_rest;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= ser_act_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ser_act_q) begin
			coin_value_q <= (ser_status_q == ST_OK) ? sel_value : COIN_NONE;
			coin_count_q <= (ser_status_q == ST_OK) ? sel_count : '0;
			status_q     <= ser_status_q;
			last_q       <= ser_last;
		end
	end

	assign strobe     = strobe_q;
	assign coin_value = coin_value_q;
	assign coin_count = coin_count_q;
	assign status     = status_q;
	assign last       = last_q;

`ifndef NO_ASSERTIONS
	// An error gives a single result, so it must close the item.
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && status_q != ST_OK |-> last_q)
		else $error("error result not marked last");

	// Results of one item leave in consecutive cycles.
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && !last_q |=> strobe_q)
		else $error("gap inside the results of one item");

	// Each non-final result retires exactly one pending denomination.
	a_mask_step: assert property (@(posedge clk) disable iff (!arst_n)
		ser_act_q && !ser_last |=>
		ser_act_q && $countones(ser_mask_q) == $countones($past(ser_mask_q)) - 1)
		else $error("serialiser pending set did not shrink by one");
`endif

endmodule

// ----- verif/greedy_coin_change_top_tb.sv -----
// Self-checking testbench for the greedy coin change block: directed table, then random items.
`timescale 1ns / 1ps

module greedy_coin_change_top_tb;
	import gcc_pkg::*;

	localparam int NUM_COINS_USED = NUM_COINS_DEF;
	localparam int FIRST_LATENCY  = 2 * NUM_COINS_USED + 2;
	localparam int QUIET_LIMIT    = 2000;
	localparam int ITEMS_PER_SET  = 25;
	localparam int SETS_PER_PHASE = 4;
	localparam int NUM_DIRECTED   = 23;

	// Coin sets used by the directed table.
	localparam int SET_RESET = 0;
	localparam int SET_TILL  = 1;
	localparam int SET_DUP   = 2;
	localparam int SET_FULL  = 3;
	localparam int SET_POW2  = 4;
	localparam int SET_OVER  = 5;
	localparam int SET_NOONE = 6;
	localparam int SET_EMPTY = 7;
	localparam int SET_TOP   = 8;
	localparam int NUM_SETS  = 9;

	typedef struct packed {
		logic [COIN_W-1:0] value;
		logic [CNT_W-1:0]  count;
		status_t           status;
		logic              last;
	} coin_result_t;

	typedef struct packed {
		logic [3:0]       set_sel;
		logic [AMT_W-1:0] amt;
		logic             typed;
		coin_result_t     res;
	} change_case_t;

	logic                   clk;
	logic                   arst_n     = 1'b0;
	logic                   start      = 1'b0;
	logic                   busy;
	logic [AMT_W-1:0]       amount     = '0;
	logic                   cfg_valid  = 1'b0;
	logic                   cfg_ready;
	logic [SLOT_IDX_W-1:0]  cfg_index  = '0;
	logic [COIN_W-1:0]      cfg_data   = '0;
	logic                   strobe;
	logic [COIN_W-1:0]      coin_value;
	logic [CNT_W-1:0]       coin_count;
	logic [STATUS_W-1:0]    status;
	logic                   last;

	// Local copy of the coin slot registers, and results still owed by the block.
	logic [COIN_W-1:0]      coin_slot [SLOT_CNT];
	coin_result_t           owed_change [$];
	logic [0:SLOT_CNT-1][COIN_W-1:0] coin_sets [NUM_SETS];
	change_case_t           directed_cases [NUM_DIRECTED];
	int                     mismatches = 0;
	int                     quiet_cycles = 0;
	int                     send_idle_pct = 0;
	bit                     sending = 1'b0;

	greedy_coin_change_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.amount     (amount),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.strobe     (strobe),
		.coin_value (coin_value),
		.coin_count (coin_count),
		.status     (status),
		.last       (last)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Greedy split of one amount over the current coin set, largest coin first.
	function automatic void predict_change(input logic [AMT_W-1:0] amt);
		logic [COIN_W-1:0] denom [SLOT_CNT];
		logic [COIN_W-1:0] v;
		logic [COIN_W-1:0] tmp;
		coin_result_t      r;
		int                n;
		int                i;
		int                j;
		bit                bad_set;
		bit                has_one;
		bit                seen;
		int unsigned       rest;
		int unsigned       cnt;
		n = 0;
		bad_set = 1'b0;
		has_one = 1'b0;
		rest = 32'(amt);
		// Gather the distinct used denominations and validate the set.
		for (i = 0; i < NUM_COINS_USED; i++) begin
			v = coin_slot[i];
			if (v != COIN_NONE) begin
				if (v > COIN_MAX)
					bad_set = 1'b1;
				if (v == COIN_ONE)
					has_one = 1'b1;
				seen = 1'b0;
				for (j = 0; j < n; j++)
					if (denom[j] == v)
						seen = 1'b1;
				if (!seen) begin
					denom[n] = v;
					n++;
				end
			end
		end
		if (bad_set || !has_one) begin
			r = '{COIN_NONE, '0, ST_BAD_SET, 1'b1};
			owed_change.push_back(r);
			return;
		end
		if (rest == 0) begin
			r = '{COIN_NONE, '0, ST_ZERO_AMT, 1'b1};
			owed_change.push_back(r);
			return;
		end
		// Order the denominations from largest to smallest.
		for (i = 0; i < n; i++)
			for (j = i + 1; j < n; j++)
				if (denom[j] > denom[i]) begin
					tmp = denom[i];
					denom[i] = denom[j];
					denom[j] = tmp;
				end
		// One result per denomination that is actually used.
		for (i = 0; i < n && rest != 0; i++) begin
			cnt = rest / denom[i];
			if (cnt != 0) begin
				rest = rest - cnt * denom[i];
				r.value = denom[i];
				r.count = cnt[CNT_W-1:0];
				r.status = ST_OK;
				r.last = (rest == 0);
				owed_change.push_back(r);
			end
		end
	endfunction

	function automatic change_case_t row(input int set_sel, input logic [AMT_W-1:0] amt,
			input bit typed, input logic [COIN_W-1:0] v, input logic [CNT_W-1:0] c,
			input status_t st);
		change_case_t t;
		t.set_sel = set_sel[3:0];
		t.amt = amt;
		t.typed = typed;
		t.res = '{v, c, st, 1'b1};
		return t;
	endfunction

	task automatic note_mismatch(input string what, input coin_result_t exp);
		mismatches++;
		if (mismatches <= 10)
			$display({"%0t: %s: expected value %0d count %0d status %0d last %0d, ",
				"got value %0d count %0d status %0d last %0d"},
				$realtime, what, exp.value, exp.count, exp.status, exp.last,
				coin_value, coin_count, status, last);
	endtask

	// Present one amount, wait for it to be taken, then idle at random.
	task automatic issue_amount(input logic [AMT_W-1:0] amt, input bit typed,
			input coin_result_t typed_res);
		start <= 1'b1;
		sending = 1'b1;
		amount <= amt;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		if (typed)
			owed_change.push_back(typed_res);
		else
			predict_change(amt);
		if ($urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
			sending = 1'b0;
			amount <= AMT_W'($urandom_range(0, 65535));
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	// Stop sending and wait until every owed result has come back.
	task automatic wait_drained();
		if (sending) begin
			start <= 1'b0;
			sending = 1'b0;
			@(posedge clk);
		end
		while (owed_change.size() != 0)
			@(posedge clk);
	endtask

	// Wait until the block is idle, then write all coin slots back to back.
	task automatic load_coins(input logic [0:SLOT_CNT-1][COIN_W-1:0] set);
		int i;
		wait_drained();
		for (i = 0; i < SLOT_CNT; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= i[SLOT_IDX_W-1:0];
			cfg_data <= set[i];
			do
				@(posedge clk);
			while (cfg_ready !== 1'b1);
			coin_slot[i] = set[i];
		end
		cfg_valid <= 1'b0;
	endtask

	// Compare each result with the oldest owed one.
	always @(posedge clk) begin
		coin_result_t exp;
		if (arst_n && strobe !== 1'b0) begin
			if (owed_change.size() == 0) begin
				exp = '0;
				note_mismatch("result with nothing owed", exp);
			end else begin
				exp = owed_change.pop_front();
				if (coin_value !== exp.value || coin_count !== exp.count ||
						status !== exp.status || last !== exp.last)
					note_mismatch("result mismatch", exp);
			end
		end
	end

	// Watchdog: ends the run when nothing has been accepted or returned for too long.
	always @(posedge clk) begin
		if ((start && !busy) || strobe || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		logic [0:SLOT_CNT-1][COIN_W-1:0] set;
		coin_result_t                    none;
		int                              loaded_set;
		int                              phase;
		int                              blk;
		int                              k;
		int                              kind;
		logic [AMT_W-1:0]                amt;

		none = '0;
		for (k = 0; k < SLOT_CNT; k++)
			coin_slot[k] = COIN_NONE;
		coin_slot[0] = COIN_ONE;

		// Slot 0 first in each set.
		coin_sets = '{
			{6'd1,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0},
			{6'd0,  6'd5,  6'd25, 6'd0,  6'd1,  6'd10, 6'd0,  6'd0},
			{6'd10, 6'd1,  6'd10, 6'd5,  6'd5,  6'd1,  6'd0,  6'd1},
			{6'd50, 6'd1,  6'd49, 6'd2,  6'd48, 6'd3,  6'd47, 6'd7},
			{6'd1,  6'd2,  6'd4,  6'd8,  6'd16, 6'd32, 6'd0,  6'd0},
			{6'd1,  6'd51, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0},
			{6'd2,  6'd5,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0},
			{6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0},
			{6'd1,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd63}
		};

		// Directed cases; typed rows carry their single result, the others are predicted.
		directed_cases = '{
			row(SET_RESET, 16'd1,     1'b1, 6'd1, 16'd1,     ST_OK),
			row(SET_RESET, 16'd65535, 1'b1, 6'd1, 16'd65535, ST_OK),
			row(SET_RESET, 16'd0,     1'b1, 6'd0, 16'd0,     ST_ZERO_AMT),
			row(SET_TILL,  16'd0,     1'b1, 6'd0, 16'd0,     ST_ZERO_AMT),
			row(SET_TILL,  16'd41,    1'b0, 6'd0, 16'd0,     ST_OK),
			row(SET_TILL,  16'd4,     1'b0, 6'd0, 16'd0,     ST_OK),
			row(SET_TILL,  16'd30,    1'b0, 6'd0, 16'd0,     ST_OK),
			row(SET_TILL,  16'd65535, 1'b0, 6'd0, 16'd0,     ST_OK),
			row(SET_DUP,   16'd16,    1'b0, 6'd0, 16'd0,     ST_OK),
			row(SET_DUP,   16'd7,     1'b0, 6'd0, 16'd0,     ST_OK),
			row(SET_DUP,   16'd10,    1'b0, 6'd0, 16'd0,     ST_OK),
			row(SET_FULL,  16'd65535, 1'b0, 6'd0, 16'd0,     ST_OK),
			row(SET_FULL,  16'd97,    1'b0, 6'd0, 16'd0,     ST_OK),
			row(SET_FULL,  16'd1,     1'b0, 6'd0, 16'd0,     ST_OK),
			row(SET_POW2,  16'd63,    1'b0, 6'd0, 16'd0,     ST_OK),
			row(SET_POW2,  16'd65535, 1'b0, 6'd0, 16'd0,     ST_OK),
			row(SET_POW2,  16'd0,     1'b1, 6'd0, 16'd0,     ST_ZERO_AMT),
			row(SET_OVER,  16'd100,   1'b1, 6'd0, 16'd0,     ST_BAD_SET),
			row(SET_OVER,  16'd0,     1'b1, 6'd0, 16'd0,     ST_BAD_SET),
			row(SET_NOONE, 16'd9,     1'b1, 6'd0, 16'd0,     ST_BAD_SET),
			row(SET_EMPTY, 16'd1,     1'b1, 6'd0, 16'd0,     ST_BAD_SET),
			row(SET_TOP,   16'd65535, 1'b1, 6'd0, 16'd0,     ST_BAD_SET),
			row(SET_TOP,   16'd0,     1'b1, 6'd0, 16'd0,     ST_BAD_SET)
		};

		// Hold reset, then release it at a rising edge.
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, starting from the coin set left by reset.
		send_idle_pct = 27;
		loaded_set = SET_RESET;
		for (k = 0; k < NUM_DIRECTED; k++) begin
			if (directed_cases[k].set_sel != loaded_set) begin
				loaded_set = directed_cases[k].set_sel;
				load_coins(coin_sets[loaded_set]);
			end
			issue_amount(directed_cases[k].amt, directed_cases[k].typed,
				directed_cases[k].res);
		end

		// Random part: three idling phases, each over several random coin sets.
		for (phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 53 : 0;
			for (blk = 0; blk < SETS_PER_PHASE; blk++) begin
				kind = $urandom_range(9);
				for (k = 0; k < SLOT_CNT; k++) begin
					if ($urandom_range(2) == 0)
						set[k] = COIN_NONE;
					else if (kind == 1)
						set[k] = COIN_W'($urandom_range(2, 50));
					else
						set[k] = COIN_W'($urandom_range(1, 50));
				end
				// Most sets are valid; a few carry an out-of-range coin or lack the unit coin.
				if (kind == 0)
					set[SLOT_IDX_W'($urandom_range(SLOT_CNT - 1))] =
						COIN_W'($urandom_range(51, 63));
				if (kind != 1)
					set[SLOT_IDX_W'($urandom_range(SLOT_CNT - 1))] = COIN_ONE;
				load_coins(set);
				for (k = 0; k < ITEMS_PER_SET; k++) begin
					kind = $urandom_range(19);
					if (kind == 0)
						amt = '0;
					else if (kind == 1)
						amt = '1;
					else if (kind < 10)
						amt = AMT_W'($urandom_range(1, 200));
					else
						amt = AMT_W'($urandom_range(0, 65535));
					issue_amount(amt, 1'b0, none);
				end
			end
		end

		// Let the pipeline empty, then give the verdict.
		wait_drained();
		repeat (FIRST_LATENCY) @(posedge clk);
		if (mismatches == 0 && owed_change.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ----- sim.f -----
src/gcc_pkg.sv
src/gcc_cfg.sv
src/gcc_rank.sv
src/greedy_coin_change_top.sv
verif/greedy_coin_change_top_tb.sv
